>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for concurrent assertions clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition in one cycle implies another condition in the next cycle.
`define ASSERT_NEXT(label, cond, expect_next, msg) \
  `ASSERT_CLK(label, (cond) |=> (expect_next), msg)

`endif

>>> rtl/bhrt_pkg.sv
// ----------------------------------------------------------------------------
// bhrt_pkg
// Types and constants of the button hold and auto-repeat tracker.
// ----------------------------------------------------------------------------
package bhrt_pkg;

  localparam int NUM_BUTTONS_DEF = 7;
  localparam int COUNT_WIDTH_DEF = 24;

  localparam int REG_W   = 24;
  localparam int MASK_W  = 7;
  localparam int QUERY_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic load;
    logic step;
    logic eval;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic last_bit;
    logic last_lane;
    logic out_free;
  } status_t;

endpackage

>>> rtl/bhrt_ctrl.sv
// ----------------------------------------------------------------------------
// bhrt_ctrl
// Sequencer that walks the buttons one at a time through the shared
// remainder unit and then hands the result beat to the output register.
// ----------------------------------------------------------------------------
module bhrt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  bhrt_pkg::status_t status,
  output bhrt_pkg::cmd_t    cmd
);
  import bhrt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (status.last_bit) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = status.last_lane ? ST_DONE : ST_LOAD;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = rst;
        cmd.start = in_valid && !rst;
      end
      ST_LOAD: cmd.load = 1'b1;
      ST_DIV:  cmd.step = 1'b1;
      ST_EVAL: cmd.eval = 1'b1;
      ST_DONE: cmd.publish = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/bhrt_datapath.sv
// ----------------------------------------------------------------------------
// bhrt_datapath
// Hold counters, configuration registers, bit-serial remainder unit,
// event mask assembly and the output register.
// ----------------------------------------------------------------------------
module bhrt_datapath #(
  parameter int NUM_BUTTONS = bhrt_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_WIDTH = bhrt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bhrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bhrt_pkg::REG_W-1:0]    cfg_data,
  input  logic [bhrt_pkg::MASK_W-1:0]   button_levels,
  input  logic [bhrt_pkg::QUERY_W-1:0]  query_button,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [bhrt_pkg::MASK_W-1:0]   pressed_mask,
  output logic [bhrt_pkg::MASK_W-1:0]   released_mask,
  output logic [bhrt_pkg::MASK_W-1:0]   held_mask,
  output logic [bhrt_pkg::MASK_W-1:0]   repeat_mask,
  output logic [bhrt_pkg::REG_W-1:0]    hold_ticks,
  input  bhrt_pkg::cmd_t                cmd,
  output bhrt_pkg::status_t             status
);
  import bhrt_pkg::*;

  localparam int LW  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int BW  = $clog2(COUNT_WIDTH);
  localparam int RW  = REG_W + 1;
  localparam int EW  = (COUNT_WIDTH > RW) ? COUNT_WIDTH : RW;
  localparam logic [COUNT_WIDTH-1:0] MARK = '1;

  logic [REG_W-1:0]       hold_time;
  logic [REG_W-1:0]       repeat_period;
  logic [COUNT_WIDTH-1:0] counts [NUM_BUTTONS];
  logic [LW-1:0]          lane;
  logic [BW-1:0]          bit_cnt;
  logic [COUNT_WIDTH-1:0] dividend;
  logic [RW-1:0]          rem;
  logic [QUERY_W-1:0]     query;
  logic [MASK_W-1:0]      pm, rm, hm, am;
  logic [REG_W-1:0]       ticks;

  logic [COUNT_WIDTH-1:0] sel_count;
  logic [RW-1:0]          rem_sh;
  logic [RW-1:0]          rem_next;
  logic [RW-1:0]          target;
  logic                   is_active;
  logic                   rep_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time     <= '0;
      repeat_period <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HOLD_TIME:     hold_time <= cfg_data;
        CFG_REPEAT_PERIOD: repeat_period <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (rst) begin
        counts[i] <= '0;
      end else if (cmd.start) begin
        if (button_levels[i]) begin
          if (counts[i] == MARK) begin
            counts[i] <= COUNT_WIDTH'(1);
          end else if (counts[i] != MARK - COUNT_WIDTH'(1)) begin
            counts[i] <= counts[i] + COUNT_WIDTH'(1);
          end
        end else if (counts[i] == MARK) begin
          counts[i] <= '0;
        end else if (counts[i] != '0) begin
          counts[i] <= MARK;
        end
      end
    end
  end

  assign sel_count = counts[lane];
  assign rem_sh    = {rem[RW-2:0], dividend[COUNT_WIDTH-1]};
  assign rem_next  = (rem_sh >= {1'b0, repeat_period}) ?
                     rem_sh - {1'b0, repeat_period} : rem_sh;
  assign target    = {1'b0, hold_time} + RW'(1);
  assign is_active = (sel_count != MARK) && (sel_count != '0);
  assign rep_hit   = (repeat_period <= REG_W'(1)) || (rem == RW'(1));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lane  <= '0;
      query <= query_button;
      pm    <= '0;
      rm    <= '0;
      hm    <= '0;
      am    <= '0;
      ticks <= '0;
    end
    if (cmd.load) begin
      dividend <= sel_count;
      rem      <= '0;
      bit_cnt  <= BW'(COUNT_WIDTH - 1);
    end
    if (cmd.step) begin
      rem      <= rem_next;
      dividend <= {dividend[COUNT_WIDTH-2:0], 1'b0};
      bit_cnt  <= bit_cnt - BW'(1);
    end
    if (cmd.eval) begin
      for (int j = 0; j < NUM_BUTTONS; j++) begin
        if (LW'(j) == lane) begin
          pm[j] <= (sel_count == COUNT_WIDTH'(1));
          rm[j] <= (sel_count == MARK);
          hm[j] <= (EW'(sel_count) == EW'(target));
          am[j] <= is_active && rep_hit;
        end
      end
      if (QUERY_W'(lane) == query) begin
        ticks <= (sel_count == MARK) ? '0 : REG_W'(sel_count);
      end
      lane <= lane + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      pressed_mask  <= pm;
      released_mask <= rm;
      held_mask     <= hm;
      repeat_mask   <= am;
      hold_ticks    <= ticks;
    end
  end

  assign status.last_bit  = (bit_cnt == '0);
  assign status.last_lane = (lane == LW'(NUM_BUTTONS - 1));
  assign status.out_free  = !out_valid || !out_stall;

endmodule

>>> rtl/button_hold_repeat_tracker.sv
// A new item is accepted only once the current result is passed to the output register;
// the pace is set by the bit-serial remainder unit shared by all buttons, one bit per cycle.
// A finished result waits in the output register while the next item is accepted.
// Reset (synchronous, active high) clears all hold counters to idle and both registers to 0.
// ----------------------------------------------------------------------------
// button_hold_repeat_tracker
// Tracks hold time of each button and reports press, release, hold and
// auto-repeat events once per tick.
// ----------------------------------------------------------------------------
module button_hold_repeat_tracker #(
  parameter int NUM_BUTTONS = bhrt_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_WIDTH = bhrt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bhrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bhrt_pkg::REG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bhrt_pkg::MASK_W-1:0]    button_levels,
  input  logic [bhrt_pkg::QUERY_W-1:0]   query_button,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bhrt_pkg::MASK_W-1:0]    pressed_mask,
  output logic [bhrt_pkg::MASK_W-1:0]    released_mask,
  output logic [bhrt_pkg::MASK_W-1:0]    held_mask,
  output logic [bhrt_pkg::MASK_W-1:0]    repeat_mask,
  output logic [bhrt_pkg::REG_W-1:0]     hold_ticks
);
  import bhrt_pkg::*;

  cmd_t    cmd;
  status_t status;

  bhrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bhrt_datapath #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .button_levels (button_levels),
    .query_button  (query_button),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .pressed_mask  (pressed_mask),
    .released_mask (released_mask),
    .held_mask     (held_mask),
    .repeat_mask   (repeat_mask),
    .hold_ticks    (hold_ticks),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

>>> rtl/bhrt_checker.sv
// ----------------------------------------------------------------------------
// bhrt_checker
// Port-level checks of the tracker, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bhrt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [bhrt_pkg::MASK_W-1:0]    pressed_mask,
  input logic [bhrt_pkg::MASK_W-1:0]    released_mask,
  input logic [bhrt_pkg::REG_W-1:0]     hold_ticks
);

  // An accepted beat keeps the input side busy in the following cycle.
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not busy after accept")

  // A stalled result beat stays valid and keeps its hold ticks and pressed mask.
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hold_ticks) && $stable(pressed_mask), "stalled result changed")

  // A new result appears only at the end of processing, while the input side is busy.
  `ASSERT_CLK(a_result_from_work, $rose(out_valid) |-> $past(in_stall), "result without work")

  // A button cannot be both newly pressed and released in one tick.
  `ASSERT_CLK(a_press_release_disjoint, out_valid |-> ((pressed_mask & released_mask) == '0), "press and release overlap")

endmodule

bind button_hold_repeat_tracker bhrt_checker u_bhrt_checker (.*);
